// ===== hw/rtl/spps_pkg.sv =====
// Shared types and constants for the shell pair proximity screen.
package spps_pkg;

    // Default shell capacity of one list
    localparam int MAX_SHELLS_DEF = 64;

    // Field widths
    localparam int COORD_W  = 32;
    localparam int EXTENT_W = 31;
    localparam int PAIR_W   = 12;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BATCH_RADIUS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN       = 3'd4;

    // Pair classes
    localparam logic CLASS_BOTH = 1'b0;
    localparam logic CLASS_ONE  = 1'b1;

    // Input word: one shell
    typedef struct packed {
        logic                       first;
        logic signed [COORD_W-1:0]  origin_x;
        logic signed [COORD_W-1:0]  origin_y;
        logic signed [COORD_W-1:0]  origin_z;
        logic [EXTENT_W-1:0]        extent;
    } shell_word_t;

    // Output word: one screened pair
    typedef struct packed {
        logic [PAIR_W-1:0] pair_index;
        logic              pair_class;
        logic              overflow;
        logic              last;
    } pair_word_t;

endpackage

// ===== hw/rtl/shell_pair_proximity_screen_core.sv =====
// Top level of the shell pair proximity screen: distance test and pair walk.
//
//  channel | ports                          | word
//  --------+--------------------------------+-------------------------------
//  input   | s_valid, s_ready, s_data       | shell_word_t (one shell)
//  output  | m_valid, m_ready, m_data       | pair_word_t (one screened pair)
//  config  | cfg_we, cfg_index, cfg_data    | 32-bit register write
//
// Shell p is taken in IDLE, runs the near test (four passes of one shared 33x33
// squaring multiplier, each through DIFF, MUL and ACC), reads flags 0 to p (one
// flag read per cycle while no output stall holds the walk) and ends in FLUSH;
// s_ready is high only in IDLE. A shell beyond capacity goes to OVF instead.
// Output stalls hold the walk while a found pair waits for the output register.
// Reset clears the shell count, not the flags; entries above the count are never read.
module shell_pair_proximity_screen_core
    import spps_pkg::*;
#(
    parameter int MAX_SHELLS = MAX_SHELLS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  shell_word_t           s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output pair_word_t            m_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int AW     = $clog2(MAX_SHELLS);
    localparam int CNT_W  = $clog2(MAX_SHELLS + 1);
    localparam int OP_W   = 33;
    localparam int PROD_W = 2 * OP_W;

    // Sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIFF  = 3'd1;
    localparam logic [2:0] ST_MUL   = 3'd2;
    localparam logic [2:0] ST_ACC   = 3'd3;
    localparam logic [2:0] ST_WALK  = 3'd4;
    localparam logic [2:0] ST_FLUSH = 3'd5;
    localparam logic [2:0] ST_OVF   = 3'd6;

    // Operand selects of the squaring unit
    localparam logic [1:0] SEL_X     = 2'd0;
    localparam logic [1:0] SEL_Y     = 2'd1;
    localparam logic [1:0] SEL_Z     = 2'd2;
    localparam logic [1:0] SEL_REACH = 2'd3;

    // Magnitude of a signed 32-bit difference
    function automatic logic [OP_W-1:0] abs_diff(input logic signed [COORD_W-1:0] a,
                                                input logic signed [COORD_W-1:0] b);
        logic signed [OP_W-1:0] d;
        d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        return d[OP_W-1] ? $unsigned(-d) : $unsigned(d);
    endfunction

    // Configuration registers
    logic signed [COORD_W-1:0] cx_reg, cy_reg, cz_reg;
    logic [EXTENT_W-1:0]       radius_reg, margin_reg;

    // Sequencer and datapath registers
    logic [2:0]                state_reg, state_next;
    logic [1:0]                sel_reg, sel_next;
    logic signed [COORD_W-1:0] ox_reg, ox_next, oy_reg, oy_next, oz_reg, oz_next;
    logic [EXTENT_W-1:0]       ext_reg, ext_next;
    logic [OP_W-1:0]           op_reg, op_next;
    logic [PROD_W-1:0]         prod_reg, prod_next;
    logic [PROD_W-1:0]         acc_reg, acc_next;
    logic                      np_reg, np_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [PAIR_W-1:0]         base_reg, base_next;
    logic [CNT_W-1:0]          q_rd_reg, q_rd_next;
    logic [AW-1:0]             cur_q_reg, cur_q_next;
    logic                      dat_vld_reg, dat_vld_next;
    logic                      pend_vld_reg, pend_vld_next;
    pair_word_t                pend_reg, pend_next;
    logic                      m_valid_reg, m_valid_next;
    pair_word_t                m_data_reg, m_data_next;

    // Flag memory
    logic                      flag_mem [MAX_SHELLS];
    logic                      rd_flag_reg;
    logic                      mem_we, rd_en;

    logic                      near_now;
    logic                      out_free;
    logic                      hit, stall, iss_done;
    logic [CNT_W-1:0]          cnt_eff;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign out_free = !m_valid_reg || m_ready;
    assign near_now = (acc_reg < prod_reg);
    assign cnt_eff  = s_data.first ? '0 : cnt_reg;
    assign hit      = dat_vld_reg && (np_reg || rd_flag_reg);
    assign stall    = hit && pend_vld_reg && !out_free;
    assign iss_done = (q_rd_reg == cnt_reg + CNT_W'(1));

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cx_reg     <= '0;
            cy_reg     <= '0;
            cz_reg     <= '0;
            radius_reg <= '0;
            margin_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_CENTER_X:     cx_reg     <= cfg_data;
                CFG_CENTER_Y:     cy_reg     <= cfg_data;
                CFG_CENTER_Z:     cz_reg     <= cfg_data;
                CFG_BATCH_RADIUS: radius_reg <= cfg_data[EXTENT_W-1:0];
                CFG_MARGIN:       margin_reg <= cfg_data[EXTENT_W-1:0];
                default: ;
            endcase
        end
    end

    // Store this shell's flag, read one flag per walk step
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            flag_mem[cnt_reg[AW-1:0]] <= near_now;
        end
        if (rd_en) begin
            rd_flag_reg <= flag_mem[q_rd_reg[AW-1:0]];
        end
    end

    // Sequencer: square and sum, compare, walk pairs, flush; report an overflow
    always_comb begin
        state_next    = state_reg;
        sel_next      = sel_reg;
        ox_next       = ox_reg;
        oy_next       = oy_reg;
        oz_next       = oz_reg;
        ext_next      = ext_reg;
        op_next       = op_reg;
        prod_next     = prod_reg;
        acc_next      = acc_reg;
        np_next       = np_reg;
        cnt_next      = cnt_reg;
        base_next     = base_reg;
        q_rd_next     = q_rd_reg;
        cur_q_next    = cur_q_reg;
        dat_vld_next  = dat_vld_reg;
        pend_vld_next = pend_vld_reg;
        pend_next     = pend_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        mem_we        = 1'b0;
        rd_en         = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    ox_next  = s_data.origin_x;
                    oy_next  = s_data.origin_y;
                    oz_next  = s_data.origin_z;
                    ext_next = s_data.extent;
                    acc_next = '0;
                    sel_next = SEL_X;
                    cnt_next = cnt_eff;
                    if (s_data.first) begin
                        base_next = '0;
                    end
                    if (cnt_eff >= CNT_W'(MAX_SHELLS)) begin
                        state_next = ST_OVF;
                    end else begin
                        state_next = ST_DIFF;
                    end
                end
            end
            ST_OVF: begin
                // drop the shell, report it once
                if (out_free) begin
                    m_valid_next           = 1'b1;
                    m_data_next.pair_index = '0;
                    m_data_next.pair_class = CLASS_BOTH;
                    m_data_next.overflow   = 1'b1;
                    m_data_next.last       = 1'b1;
                    state_next             = ST_IDLE;
                end
            end
            ST_DIFF: begin
                case (sel_reg)
                    SEL_X:   op_next = abs_diff(ox_reg, cx_reg);
                    SEL_Y:   op_next = abs_diff(oy_reg, cy_reg);
                    SEL_Z:   op_next = abs_diff(oz_reg, cz_reg);
                    default: op_next = {2'b00, radius_reg} + {2'b00, margin_reg}
                                       + {2'b00, ext_reg};
                endcase
                state_next = ST_MUL;
            end
            ST_MUL: begin
                prod_next  = op_reg * op_reg;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                if (sel_reg != SEL_REACH) begin
                    acc_next   = acc_reg + prod_reg;
                    sel_next   = sel_reg + 2'd1;
                    state_next = ST_DIFF;
                end else begin
                    // squared distance against squared reach
                    np_next       = near_now;
                    mem_we        = 1'b1;
                    q_rd_next     = '0;
                    dat_vld_next  = 1'b0;
                    pend_vld_next = 1'b0;
                    state_next    = ST_WALK;
                end
            end
            ST_WALK: begin
                if (!stall) begin
                    // hold one found pair back until the next one shows
                    if (hit) begin
                        if (pend_vld_reg) begin
                            m_valid_next = 1'b1;
                            m_data_next  = pend_reg;
                        end
                        pend_vld_next        = 1'b1;
                        pend_next.pair_index = base_reg + PAIR_W'(cur_q_reg);
                        pend_next.pair_class = (np_reg && rd_flag_reg) ? CLASS_BOTH
                                                                       : CLASS_ONE;
                        pend_next.overflow   = 1'b0;
                        pend_next.last       = 1'b0;
                    end
                    // advance the flag read
                    if (!iss_done) begin
                        rd_en        = 1'b1;
                        cur_q_next   = q_rd_reg[AW-1:0];
                        q_rd_next    = q_rd_reg + CNT_W'(1);
                        dat_vld_next = 1'b1;
                    end else begin
                        dat_vld_next = 1'b0;
                        if (!dat_vld_reg) begin
                            state_next = ST_FLUSH;
                        end
                    end
                end
            end
            ST_FLUSH: begin
                // send the held pair as last, then advance the counters
                if (!pend_vld_reg || out_free) begin
                    if (pend_vld_reg) begin
                        m_valid_next     = 1'b1;
                        m_data_next      = pend_reg;
                        m_data_next.last = 1'b1;
                    end
                    pend_vld_next = 1'b0;
                    cnt_next      = cnt_reg + CNT_W'(1);
                    base_next     = base_reg + PAIR_W'(cnt_reg) + PAIR_W'(1);
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            base_reg     <= '0;
            dat_vld_reg  <= 1'b0;
            pend_vld_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            base_reg     <= base_next;
            dat_vld_reg  <= dat_vld_next;
            pend_vld_reg <= pend_vld_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        sel_reg    <= sel_next;
        ox_reg     <= ox_next;
        oy_reg     <= oy_next;
        oz_reg     <= oz_next;
        ext_reg    <= ext_next;
        op_reg     <= op_next;
        prod_reg   <= prod_next;
        acc_reg    <= acc_next;
        np_reg     <= np_next;
        q_rd_reg   <= q_rd_next;
        cur_q_reg  <= cur_q_next;
        pend_reg   <= pend_next;
        m_data_reg <= m_data_next;
    end

`ifndef ASSERT_OFF
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_SHELLS))
        else $error("shell count above capacity");

    a_ovf_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg.overflow |->
            m_data_reg.last && (m_data_reg.pair_index == '0))
        else $error("overflow word not a lone last word");

    a_walk_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK) |-> (q_rd_reg <= cnt_reg + CNT_W'(1)))
        else $error("flag read ran past the current shell");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK) && !iss_done |=> !s_ready)
        else $error("input taken during pair walk");
`endif

endmodule
